// ===== rtl/core/mmr_pkg.sv =====
// Shared types and constants of the matrix multiply row engine.
package mmr_pkg;

  localparam int IDX_W    = 6;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 38;
  localparam int SIZE_W   = 7;
  localparam int SIZE_CAP = 64;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_ROW     = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE_A,
    CMD_WRITE_B,
    CMD_ROW,
    CMD_BAD_ROW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [ELEM_W-1:0]   elem;
  } cmd_t;

endpackage

// ===== rtl/core/mmr_front.sv =====
// Request decoder that classifies incoming requests into queued commands.
module mmr_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic [mmr_pkg::IDX_W-1:0]          in_row_index,
  input  logic [mmr_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [mmr_pkg::ELEM_W-1:0]  in_element,
  input  logic [mmr_pkg::SIZE_W-1:0]         size,
  input  logic                               fifo_full,
  output logic                               push,
  output mmr_pkg::cmd_t                      cmd
);
  import mmr_pkg::*;

  logic in_store;
  logic row_bad;
  logic keep;

  assign in_store = (32'(in_row_index) < MAX_DIM) && (32'(in_col_index) < MAX_DIM);
  assign row_bad  = ({1'b0, in_row_index} >= size);
  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full && keep;

  always_comb begin
    cmd.kind = CMD_WRITE_A;
    cmd.row  = in_row_index;
    cmd.col  = in_col_index;
    cmd.elem = in_element;
    keep     = 1'b0;
    case (in_opcode)
      OP_WRITE_A: begin
        cmd.kind = CMD_WRITE_A;
        keep     = in_store;
      end
      OP_WRITE_B: begin
        cmd.kind = CMD_WRITE_B;
        keep     = in_store;
      end
      OP_ROW: begin
        cmd.kind = row_bad ? CMD_BAD_ROW : CMD_ROW;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/mmr_cmd_fifo.sv =====
// Short command queue between the request decoder and the compute back end.
module mmr_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mmr_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output mmr_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import mmr_pkg::*;

  cmd_t                  slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_r;
  logic [FIFO_PTR_W-1:0] rptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mmr_back.sv =====
// Compute back end: matrix stores, shared multiply-accumulate pipeline and result register.
module mmr_back #(
  parameter int MAX_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mmr_pkg::SIZE_W-1:0]          size,
  input  logic                                cmd_valid,
  input  mmr_pkg::cmd_t                       cmd,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mmr_pkg::PROD_W-1:0]   out_product,
  output logic [mmr_pkg::IDX_W-1:0]           out_column,
  output logic                                out_last_of_row,
  output logic                                out_row_error
);
  import mmr_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MUL_W  = 2 * ELEM_W;

  typedef enum logic {
    ST_IDLE,
    ST_ROW
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             last_col;
    logic             err;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic [ELEM_W-1:0]        mem_a [DEPTH];
  logic [ELEM_W-1:0]        mem_b [DEPTH];
  logic signed [ELEM_W-1:0] rd_a_r;
  logic signed [ELEM_W-1:0] rd_b_r;

  state_t                   state_r;
  logic [IDX_W-1:0]         row_r;
  logic [IDX_W-1:0]         j_r;
  logic [IDX_W-1:0]         k_r;
  tag_t                     s1_nxt;
  tag_t                     s1_r;
  tag_t                     s2_r;
  logic signed [MUL_W-1:0]  prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_nxt;
  logic                     out_valid_r;
  logic signed [PROD_W-1:0] out_product_r;
  logic [IDX_W-1:0]         out_column_r;
  logic                     out_last_r;
  logic                     out_err_r;

  logic                     adv;
  logic                     k_last;
  logic                     j_last;
  logic [SIZE_W-1:0]        size_m1;
  logic [ADDR_W-1:0]        raddr_a;
  logic [ADDR_W-1:0]        raddr_b;
  logic [ADDR_W-1:0]        waddr;

  assign adv     = !out_valid_r || !out_stall;
  assign cmd_pop = adv && (state_r == ST_IDLE) && cmd_valid;
  assign size_m1 = size - SIZE_W'(1);
  assign k_last  = ({1'b0, k_r} == size_m1);
  assign j_last  = ({1'b0, j_r} == size_m1);

  assign raddr_a = ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r);
  assign raddr_b = ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r);
  assign waddr   = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);

  assign acc_nxt = (s2_r.first ? '0 : acc_r)
                 + {{(PROD_W - MUL_W){prod_r[MUL_W-1]}}, prod_r};

  always_comb begin
    s1_nxt = '0;
    if (state_r == ST_ROW) begin
      s1_nxt.valid    = 1'b1;
      s1_nxt.first    = (k_r == '0);
      s1_nxt.last     = k_last;
      s1_nxt.last_col = j_last;
      s1_nxt.col      = j_r;
    end else if (cmd_pop && (cmd.kind == CMD_BAD_ROW)) begin
      s1_nxt.valid    = 1'b1;
      s1_nxt.first    = 1'b1;
      s1_nxt.last     = 1'b1;
      s1_nxt.last_col = 1'b1;
      s1_nxt.err      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == CMD_WRITE_A)) begin
      mem_a[waddr] <= cmd.elem;
    end
    if (adv) begin
      rd_a_r <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == CMD_WRITE_B)) begin
      mem_b[waddr] <= cmd.elem;
    end
    if (adv) begin
      rd_b_r <= mem_b[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      case (state_r)
        ST_IDLE: begin
          if (cmd_pop && (cmd.kind == CMD_ROW)) begin
            state_r <= ST_ROW;
            row_r   <= cmd.row;
            j_r     <= '0;
            k_r     <= '0;
          end
        end
        ST_ROW: begin
          if (k_last) begin
            k_r <= '0;
            if (j_last) begin
              state_r <= ST_IDLE;
            end else begin
              j_r <= j_r + IDX_W'(1);
            end
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      s1_r   <= s1_nxt;
      s2_r   <= s1_r;
      if (s1_r.err) begin
        prod_r <= '0;
      end else begin
        prod_r <= rd_a_r * rd_b_r;
      end
      if (s2_r.valid) begin
        acc_r <= acc_nxt;
      end
      out_valid_r <= s2_r.valid && s2_r.last;
      if (s2_r.valid && s2_r.last) begin
        out_product_r <= acc_nxt;
        out_column_r  <= s2_r.col;
        out_last_r    <= s2_r.last_col;
        out_err_r     <= s2_r.err;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_product     = out_product_r;
  assign out_column      = out_column_r;
  assign out_last_of_row = out_last_r;
  assign out_row_error   = out_err_r;

endmodule

// ===== rtl/core/matrix_multiply_row_engine.sv =====
// Top level of the matrix multiply row engine: size register, decoder, queue and back end.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  in_opcode, in_row_index, in_col_index, in_element
//   out      output     out_valid/out_stall out_product, out_column, out_last_of_row,
//                                          out_row_error
//   cfg      input      cfg_wr_en          cfg_wr_data (matrix size)
//
// Element writes are done in the back end as they leave the queue; a row request holds
// the back end, one multiply-accumulate per cycle on the single shared unit unless a
// stalled result holds it. Each product passes the store read registers, the product
// register and the accumulator; the result of each column is then registered.
// A four-entry command queue lets new requests be taken while a row is being computed.
// Reset empties the queue and pipeline and sets the size to MAX_DIM, at most 64; the
// matrix stores are not cleared. A stalled result freezes the pipeline until it is taken.
module matrix_multiply_row_engine #(
  parameter int MAX_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_opcode,
  input  logic [mmr_pkg::IDX_W-1:0]           in_row_index,
  input  logic [mmr_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [mmr_pkg::ELEM_W-1:0]   in_element,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mmr_pkg::PROD_W-1:0]   out_product,
  output logic [mmr_pkg::IDX_W-1:0]           out_column,
  output logic                                out_last_of_row,
  output logic                                out_row_error,
  input  logic                                cfg_wr_en,
  input  logic [mmr_pkg::SIZE_W-1:0]          cfg_wr_data
);
  import mmr_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_LIM =
    SIZE_W'((MAX_DIM < SIZE_CAP) ? MAX_DIM : SIZE_CAP);

  function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s == '0) begin
      s = SIZE_W'(1);
    end
    if (s > SIZE_LIM) begin
      s = SIZE_LIM;
    end
    return s;
  endfunction

  logic [SIZE_W-1:0] size_r;
  logic              fifo_full;
  logic              push;
  cmd_t              push_cmd;
  logic              head_valid;
  cmd_t              head_cmd;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_LIM;
    end else if (cfg_wr_en) begin
      size_r <= limit_size(cfg_wr_data);
    end
  end

  mmr_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_element   (in_element),
    .size         (size_r),
    .fifo_full    (fifo_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  mmr_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  mmr_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .size            (size_r),
    .cmd_valid       (head_valid),
    .cmd             (head_cmd),
    .cmd_pop         (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_product     (out_product),
    .out_column      (out_column),
    .out_last_of_row (out_last_of_row),
    .out_row_error   (out_row_error)
  );

endmodule
